/* rtl/core/qat_pkg.sv */
// Shared types, character codes and helpers for the quoted argument tokenizer.
package qat_pkg;

    typedef enum logic [1:0] {
        MODE_NORMAL  = 2'd0,
        MODE_SINGLE  = 2'd1,
        MODE_DOUBLE  = 2'd2,
        MODE_COMMENT = 2'd3
    } t_mode;

    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_DQ   = 8'h22;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_SQ   = 8'h27;
    localparam logic [7:0] CH_BSL  = 8'h5C;

    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // most result words one input byte can produce
    localparam int RES_MAX = 3;

    typedef logic [1:0] t_res_cnt;

    typedef struct packed {
        logic       kind;
        logic [7:0] ch;
        logic       last;
    } t_res;

    typedef t_res [RES_MAX-1:0] t_res_vec;

    typedef struct packed {
        t_mode mode;
        logic  held;
        logic  esc;
        logic  nonempty;
        logic  stopped;
    } t_state;

    localparam t_state STATE_RESET = '{
        mode:     MODE_NORMAL,
        held:     1'b0,
        esc:      1'b0,
        nonempty: 1'b0,
        stopped:  1'b0
    };

    function automatic t_res mk_res(logic kind, logic [7:0] ch);
        t_res r;
        r.kind = kind;
        r.ch   = ch;
        r.last = 1'b0;
        return r;
    endfunction

endpackage

/* rtl/core/quoted_argument_tokenizer.sv */
// Top level of the quoted argument tokenizer: input register, parser state, result holder.
//
//   channel   direction  handshake                  words
//   input     in         i_valid / o_ready          i_text_byte, i_final_byte
//   result    out        o_valid / i_ready          o_item_kind, o_out_char, o_run_last
//   config    in         i_cfg_valid / o_cfg_ready  i_cfg_first_only
//
// A byte is registered on acceptance and parsed in the next cycle, or later while the
// result holder is busy; its results appear in the cycle after the parse. One byte per
// cycle while each byte gives at most one result word and i_ready stays high; a byte
// that gives more words holds the parser while the result holder drains one word per
// cycle with i_ready high. Bytes with no results pass at full rate. Reset (synchronous,
// active low) clears the parser state and both stages; the config port is always ready.
module quoted_argument_tokenizer import qat_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_text_byte,
    input  logic       i_final_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_item_kind,
    output logic [7:0] o_out_char,
    output logic       o_run_last,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_first_only
);

    logic       r_in_valid;
    logic       n_in_valid;
    logic [7:0] r_byte;
    logic       r_fin;
    logic       r_first_only;
    t_state     r_state;

    t_state     step_state;
    t_res_cnt   step_cnt;
    t_res_vec   step_res;
    logic       q_free;
    logic       fire;
    t_res       q_res;

    qat_step u_step (
        .i_state      (r_state),
        .i_first_only (r_first_only),
        .i_byte       (r_byte),
        .i_fin        (r_fin),
        .o_state      (step_state),
        .o_cnt        (step_cnt),
        .o_res        (step_res)
    );

    qat_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (fire && step_cnt != '0),
        .i_cnt   (step_cnt),
        .i_res   (step_res),
        .o_free  (q_free),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (q_res)
    );

    // a byte with no result words never waits on the holder
    assign fire        = r_in_valid && (step_cnt == '0 || q_free);
    assign o_ready     = !r_in_valid || fire;
    assign o_cfg_ready = 1'b1;
    assign n_in_valid  = (i_valid && o_ready) || (r_in_valid && !fire);

    assign o_item_kind = q_res.kind;
    assign o_out_char  = q_res.ch;
    assign o_run_last  = q_res.last;

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_byte <= i_text_byte;
            r_fin  <= i_final_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_first_only <= 1'b0;
            r_state      <= STATE_RESET;
        end else begin
            r_in_valid <= n_in_valid;
            if (i_cfg_valid) begin
                r_first_only <= i_cfg_first_only;
            end
            if (fire) begin
                r_state <= step_state;
            end
        end
    end

endmodule

/* rtl/core/qat_step.sv */
// Per-byte tokenizer logic: next parser state and up to three result words.
module qat_step import qat_pkg::*; (
    input  t_state     i_state,
    input  logic       i_first_only,
    input  logic [7:0] i_byte,
    input  logic       i_fin,
    output t_state     o_state,
    output t_res_cnt   o_cnt,
    output t_res_vec   o_res
);

    always_comb begin
        t_state   s;
        t_res_cnt n;
        t_res_vec r;
        logic     done;
        logic     fin_stop;

        s        = i_state;
        n        = '0;
        r        = '0;
        done     = 1'b0;
        fin_stop = 1'b0;

        if (!s.stopped) begin
            // held line end in a comment: only LF keeps the comment going
            if (s.held) begin
                s.held = 1'b0;
                if (i_byte != CH_LF) begin
                    s.mode = MODE_NORMAL;
                    if (s.nonempty) begin
                        r[n]       = mk_res(KIND_END, CH_NUL);
                        n          = n + 2'd1;
                        s.nonempty = 1'b0;
                        if (i_first_only) begin
                            s.stopped = 1'b1;
                            done      = 1'b1;
                        end
                    end
                end
            end

            if (!done && i_byte != CH_NUL) begin
                if (s.esc) begin
                    s.esc = 1'b0;
                    if (s.mode != MODE_COMMENT) begin
                        r[n]       = mk_res(KIND_CHAR, i_byte);
                        n          = n + 2'd1;
                        s.nonempty = 1'b1;
                    end
                end else begin
                    case (i_byte)
                        CH_SQ: begin
                            if (s.mode == MODE_NORMAL) begin
                                s.mode = MODE_SINGLE;
                            end else if (s.mode == MODE_SINGLE) begin
                                s.mode = MODE_NORMAL;
                            end
                        end
                        CH_DQ: begin
                            if (s.mode == MODE_NORMAL) begin
                                s.mode = MODE_DOUBLE;
                            end else if (s.mode == MODE_DOUBLE) begin
                                s.mode = MODE_NORMAL;
                            end
                        end
                        CH_CR, CH_LF, CH_SP, CH_TAB: begin
                            if (s.mode == MODE_COMMENT) begin
                                if (i_byte == CH_CR || i_byte == CH_LF) begin
                                    s.held = 1'b1;
                                end
                            end else if (s.mode == MODE_NORMAL) begin
                                if (s.nonempty) begin
                                    r[n]       = mk_res(KIND_END, CH_NUL);
                                    n          = n + 2'd1;
                                    s.nonempty = 1'b0;
                                    if (i_first_only) begin
                                        s.stopped = 1'b1;
                                    end
                                end
                            end else begin
                                r[n]       = mk_res(KIND_CHAR, i_byte);
                                n          = n + 2'd1;
                                s.nonempty = 1'b1;
                            end
                        end
                        CH_BSL: begin
                            s.esc = 1'b1;
                        end
                        CH_HASH: begin
                            s.mode = MODE_COMMENT;
                        end
                        default: begin
                            if (s.mode != MODE_COMMENT) begin
                                r[n]       = mk_res(KIND_CHAR, i_byte);
                                n          = n + 2'd1;
                                s.nonempty = 1'b1;
                            end
                        end
                    endcase
                end
            end

            // end of text: zero byte, or flush after the final byte
            if (!done && (i_byte == CH_NUL || (!s.stopped && i_fin))) begin
                if (s.held) begin
                    s.held = 1'b0;
                    s.mode = MODE_NORMAL;
                    if (s.nonempty) begin
                        r[n]       = mk_res(KIND_END, CH_NUL);
                        n          = n + 2'd1;
                        s.nonempty = 1'b0;
                        if (i_first_only) begin
                            s.stopped = 1'b1;
                            fin_stop  = 1'b1;
                        end
                    end
                end
                if (!fin_stop) begin
                    if (s.esc) begin
                        s.esc = 1'b0;
                        if (s.mode != MODE_COMMENT) begin
                            r[n]       = mk_res(KIND_CHAR, CH_BSL);
                            n          = n + 2'd1;
                            s.nonempty = 1'b1;
                        end
                    end
                    if (s.nonempty) begin
                        r[n]       = mk_res(KIND_END, CH_NUL);
                        n          = n + 2'd1;
                        s.nonempty = 1'b0;
                    end
                    s.stopped = 1'b1;
                end
            end
        end

        if (n != '0) begin
            r[n - 2'd1].last = 1'b1;
        end

        o_state = s;
        o_cnt   = n;
        o_res   = r;
    end

endmodule

/* rtl/core/qat_outq.sv */
// Result holder: takes a byte's words at once, hands out one per cycle while i_ready.
module qat_outq import qat_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_load,
    input  t_res_cnt i_cnt,
    input  t_res_vec i_res,
    output logic     o_free,
    output logic     o_valid,
    input  logic     i_ready,
    output t_res     o_res
);

    t_res_vec r_slot;
    t_res_vec n_slot;
    t_res_cnt r_rem;
    t_res_cnt n_rem;
    logic     pop;

    assign o_valid = (r_rem != '0);
    assign o_res   = r_slot[0];
    assign pop     = o_valid && i_ready;
    // free next edge if empty, or the last word leaves now
    assign o_free  = (r_rem == '0) || (r_rem == 2'd1 && i_ready);

    always_comb begin
        n_slot = r_slot;
        n_rem  = r_rem;
        if (i_load) begin
            n_slot = i_res;
            n_rem  = i_cnt;
        end else if (pop) begin
            for (int i = 0; i < RES_MAX - 1; i++) begin
                n_slot[i] = r_slot[i + 1];
            end
            n_rem = r_rem - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
        if (!i_rst_n) begin
            r_rem <= '0;
        end else begin
            r_rem <= n_rem;
        end
    end

endmodule

/* sim/tokenizer_checker.sv */
// Checker for the quoted argument tokenizer: tracks the parse state and compares result words.
module tokenizer_checker import qat_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_text_byte,
    input  logic       i_final_byte,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic       i_item_kind,
    input  logic [7:0] i_out_char,
    input  logic       i_run_last,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic       i_cfg_first_only,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_words_checked,
    output int         o_args_closed
);

    t_mode tok_mode;
    logic  tok_held;
    logic  tok_esc;
    logic  tok_nonempty;
    logic  tok_stopped;
    logic  cfg_first_only;

    t_res  step_words[$];
    t_res  expected_words[$];

    function automatic void emit_word(logic kind, logic [7:0] ch);
        t_res w;
        w.kind = kind;
        w.ch   = ch;
        w.last = 1'b0;
        if (step_words.size() < RES_MAX)
            step_words = {step_words, w};
    endfunction

    function automatic void add_char(logic [7:0] ch);
        if (tok_mode != MODE_COMMENT) begin
            emit_word(KIND_CHAR, ch);
            tok_nonempty = 1'b1;
        end
    endfunction

    // closes a non-empty argument; returns 1 when first-only mode halts the parser
    function automatic logic split_arg();
        if (!tok_nonempty)
            return 1'b0;
        emit_word(KIND_END, CH_NUL);
        tok_nonempty = 1'b0;
        if (cfg_first_only) begin
            tok_stopped = 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void end_text();
        if (tok_held) begin
            tok_held = 1'b0;
            tok_mode = MODE_NORMAL;
            if (split_arg())
                return;
        end
        if (tok_esc) begin
            tok_esc = 1'b0;
            add_char(CH_BSL);
        end
        if (tok_nonempty) begin
            emit_word(KIND_END, CH_NUL);
            tok_nonempty = 1'b0;
        end
        tok_stopped = 1'b1;
    endfunction

    function automatic void tokenize_byte(logic [7:0] c, logic fin);
        logic halted;
        t_res w;
        halted = 1'b0;
        step_words.delete();
        if (tok_stopped)
            return;
        // a held line end in a comment is settled by the byte after it
        if (tok_held) begin
            tok_held = 1'b0;
            if (c != CH_LF) begin
                tok_mode = MODE_NORMAL;
                halted = split_arg();
            end
        end
        if (!halted) begin
            if (c == CH_NUL) begin
                end_text();
            end else begin
                if (tok_esc) begin
                    tok_esc = 1'b0;
                    add_char(c);
                end else begin
                    case (c)
                        CH_SQ: begin
                            if (tok_mode == MODE_NORMAL)
                                tok_mode = MODE_SINGLE;
                            else if (tok_mode == MODE_SINGLE)
                                tok_mode = MODE_NORMAL;
                        end
                        CH_DQ: begin
                            if (tok_mode == MODE_NORMAL)
                                tok_mode = MODE_DOUBLE;
                            else if (tok_mode == MODE_DOUBLE)
                                tok_mode = MODE_NORMAL;
                        end
                        CH_CR, CH_LF: begin
                            if (tok_mode == MODE_COMMENT)
                                tok_held = 1'b1;
                            else if (tok_mode == MODE_NORMAL)
                                void'(split_arg());
                            else
                                add_char(c);
                        end
                        CH_SP, CH_TAB: begin
                            if (tok_mode == MODE_NORMAL)
                                void'(split_arg());
                            else
                                add_char(c);
                        end
                        CH_BSL:  tok_esc = 1'b1;
                        CH_HASH: tok_mode = MODE_COMMENT;
                        default: add_char(c);
                    endcase
                end
                if (!tok_stopped && fin)
                    end_text();
            end
        end
        foreach (step_words[k]) begin
            w = step_words[k];
            w.last = (k == step_words.size() - 1);
            expected_words = {expected_words, w};
        end
    endfunction

    task automatic log_failure(string what);
        o_fail_count++;
        if (o_fail_count <= 10)
            $display("[%0t] %s", $realtime, what);
    endtask

    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            tok_mode        = MODE_NORMAL;
            tok_held        = 1'b0;
            tok_esc         = 1'b0;
            tok_nonempty    = 1'b0;
            tok_stopped     = 1'b0;
            cfg_first_only  = 1'b0;
            expected_words.delete();
            o_fail_count    = 0;
            o_words_checked = 0;
            o_args_closed   = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                o_words_checked++;
                if (i_item_kind === KIND_END)
                    o_args_closed++;
                if (expected_words.size() == 0) begin
                    log_failure($sformatf("unexpected word: kind=%0b char=%02h last=%0b",
                                          i_item_kind, i_out_char, i_run_last));
                end else begin
                    want = expected_words.pop_front();
                    if (i_item_kind !== want.kind || i_out_char !== want.ch ||
                        i_run_last !== want.last)
                        log_failure($sformatf(
                            {"word %0d: expected kind=%0b char=%02h last=%0b, ",
                             "got kind=%0b char=%02h last=%0b"},
                            o_words_checked, want.kind, want.ch, want.last,
                            i_item_kind, i_out_char, i_run_last));
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                cfg_first_only = i_cfg_first_only;
            if (i_in_valid && i_in_ready)
                tokenize_byte(i_text_byte, i_final_byte);
        end
        o_pending = expected_words.size();
    end

endmodule

/* sim/tb_top.sv */
// Testbench top for the quoted argument tokenizer: stimulus, handshake pressure and verdict.
module tb_top import qat_pkg::*; ();

    localparam int PHASES          = 4;
    localparam int ITEMS_PER_PHASE = 98;
    localparam int IDLE_PCT  [PHASES] = '{0, 74, 0, 9};
    localparam int STALL_PCT [PHASES] = '{0, 0, 74, 9};

    // comment, quoting and escape corners, ends with a line end held in a comment
    localparam logic [7:0] OPENING_TEXT [25] = '{
        8'h61, 8'hFF, CH_SP, 8'h01, CH_TAB, CH_SQ, CH_DQ, CH_SP, CH_HASH, CH_SQ,
        CH_CR, CH_LF, CH_BSL, CH_SP, CH_DQ, CH_BSL, CH_DQ, CH_CR, CH_DQ, CH_LF,
        CH_HASH, CH_BSL, CH_LF, 8'h71, CH_LF
    };

    logic       i_clk;
    logic       i_rst_n          = 1'b0;
    logic       i_valid          = 1'b0;
    logic       o_ready;
    logic [7:0] i_text_byte      = 8'h00;
    logic       i_final_byte     = 1'b0;
    logic       o_valid;
    logic       i_ready          = 1'b0;
    logic       o_item_kind;
    logic [7:0] o_out_char;
    logic       o_run_last;
    logic       i_cfg_valid      = 1'b0;
    logic       o_cfg_ready;
    logic       i_cfg_first_only = 1'b0;

    int fail_count;
    int pending;
    int words_checked;
    int args_closed;
    int bytes_sent = 0;
    int idle_pct   = 0;
    int stall_pct  = 0;

    quoted_argument_tokenizer dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_text_byte      (i_text_byte),
        .i_final_byte     (i_final_byte),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_item_kind      (o_item_kind),
        .o_out_char       (o_out_char),
        .o_run_last       (o_run_last),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_first_only (i_cfg_first_only)
    );

    tokenizer_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_valid),
        .i_in_ready       (o_ready),
        .i_text_byte      (i_text_byte),
        .i_final_byte     (i_final_byte),
        .i_out_valid      (o_valid),
        .i_out_ready      (i_ready),
        .i_item_kind      (o_item_kind),
        .i_out_char       (o_out_char),
        .i_run_last       (o_run_last),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_first_only (i_cfg_first_only),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_words_checked  (words_checked),
        .o_args_closed    (args_closed)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(negedge i_clk)
        i_ready <= ($urandom_range(99) >= stall_pct);

    // weighted toward separators, quotes, escapes and comments so every mode is visited
    function automatic logic [7:0] pick_text_byte();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 40) return 8'($urandom_range(8'h7A, 8'h61));
        if (roll < 50) return CH_SP;
        if (roll < 54) return CH_TAB;
        if (roll < 59) return CH_LF;
        if (roll < 62) return CH_CR;
        if (roll < 67) return CH_SQ;
        if (roll < 72) return CH_DQ;
        if (roll < 78) return CH_BSL;
        if (roll < 82) return CH_HASH;
        return 8'($urandom_range(255, 1));
    endfunction

    // entered and left at a falling edge
    task automatic send_byte(input logic [7:0] c, input logic fin);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_text_byte  <= c;
        i_final_byte <= fin;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
        bytes_sent++;
    endtask

    task automatic wait_idle();
        int guard;
        guard = 0;
        i_valid <= 1'b0;
        while (pending != 0 && guard < 5000) begin
            @(negedge i_clk);
            guard++;
        end
        // bytes with no results may still sit in the pipeline
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_first_only(input logic value);
        i_cfg_valid      <= 1'b1;
        i_cfg_first_only <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        write_first_only(1'b0);
        foreach (OPENING_TEXT[k])
            send_byte(OPENING_TEXT[k], 1'b0);

        // text must stay open here: no zero byte, no final flag
        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            write_first_only(1'b0);
            idle_pct  = IDLE_PCT[p];
            stall_pct = STALL_PCT[p];
            repeat (ITEMS_PER_PHASE)
                send_byte(pick_text_byte(), 1'b0);
        end

        // closing: first-only on, then one of the ways the text can end
        wait_idle();
        write_first_only(1'b1);
        idle_pct  = 9;
        stall_pct = 9;
        repeat ($urandom_range(3))
            send_byte(pick_text_byte(), 1'b0);
        case ($urandom_range(4))
            0: send_byte(CH_NUL, 1'($urandom_range(1)));
            1: begin
                send_byte(CH_BSL, 1'b0);
                send_byte(CH_NUL, 1'b1);
            end
            2: begin
                send_byte(CH_BSL, 1'b0);
                send_byte(pick_text_byte(), 1'b1);
            end
            3: begin
                send_byte(CH_HASH, 1'b0);
                send_byte(CH_CR, 1'b0);
                send_byte(CH_NUL, 1'b0);
            end
            default: send_byte(8'h7A, 1'b1);
        endcase
        // bytes after the end must be swallowed
        for (int k = 0; k < 4; k++)
            send_byte(8'($urandom_range(255)), k[0]);

        wait_idle();
        $display("Sent %0d text bytes across %0d handshake phases plus a closing phase.",
                 bytes_sent, PHASES);
        $display("Checked %0d result words, %0d of them argument ends.",
                 words_checked, args_closed);
        if (pending != 0)
            $display("%0d expected result words never arrived", pending);
        if (fail_count == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #2000000;
        $display("Timed out waiting for the tokenizer");
        $display("Mismatches found");
        $finish;
    end

endmodule

/* files.f */
rtl/core/qat_pkg.sv
rtl/core/qat_step.sv
rtl/core/qat_outq.sv
rtl/core/quoted_argument_tokenizer.sv
sim/tokenizer_checker.sv
sim/tb_top.sv
